// ===== src/btb_pkg.sv =====
package btb_pkg;

    localparam int ENTRY_BITS = 5;
    localparam int ENTRIES    = 1 << ENTRY_BITS;
    localparam int HIST_BITS  = 8;
    localparam int ROW_LEN    = 1 << HIST_BITS;
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = ADDR_W - 2;
    localparam int CFG_W      = 5;

    typedef enum logic [2:0] {
        CFG_INDEX_BITS   = 3'd0,
        CFG_HISTORY_BITS = 3'd1,
        CFG_TAG_BITS     = 3'd2,
        CFG_INIT_COUNTER = 3'd3,
        CFG_GLOBAL_HIST  = 3'd4,
        CFG_GLOBAL_CNT   = 3'd5,
        CFG_SHARE_MODE   = 3'd6,
        CFG_UNUSED       = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LOW  = 2'd1,
        SHARE_HIGH = 2'd2,
        SHARE_RSVD = 2'd3
    } t_share;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [ADDR_W-1:0]    target;
        logic [HIST_BITS-1:0] hist;
    } t_entry;

    function automatic logic [1:0] step_counter(input logic [1:0] c, input logic t);
        logic [1:0] r;
        if (t) begin
            r = (c == 2'd3) ? c : c + 2'd1;
        end else begin
            r = (c == 2'd0) ? c : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== src/btb_req_if.sv =====
interface btb_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [btb_pkg::ADDR_W-1:0]   pc;
    logic [btb_pkg::ADDR_W-1:0]   target;
    logic                         taken;

    modport source (output valid, op, pc, target, taken, input ready);
    modport sink (input valid, op, pc, target, taken, output ready);
endinterface

// ===== src/btb_rsp_if.sv =====
interface btb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         predicted_taken;
    logic [btb_pkg::ADDR_W-1:0]   predicted_target;
    logic [31:0]                  branch_count;
    logic [31:0]                  flush_count;

    modport source (output valid, predicted_taken, predicted_target, branch_count,
                    flush_count, input ready);
    modport sink (input valid, predicted_taken, predicted_target, branch_count,
                  flush_count, output ready);
endinterface

// ===== src/btb_two_level_branch_predictor.sv =====
// Branch target buffer with two-bit direction counters. Each request beat (predict or
// update) passes idle (accept, entry memory read), read (counter memory read) and exec
// (result and all write-backs, held while the output register is full and unread); a new
// request is accepted once back in idle. An update that allocates an entry while per-entry
// counter rows are in use then walks all 2^history_bits counters of that row to the initial
// value (the used one stepped by its outcome), one counter a cycle, with no request taken
// meanwhile. The result sits in an output register, so one finished beat may wait while the
// next is accepted. Config writes clear valid bits, history and counts; no clearing pass runs.
module btb_two_level_branch_predictor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    btb_req_if.sink                 i_req,
    btb_rsp_if.source               o_rsp,
    input  logic                    i_cfg_we,
    input  btb_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [btb_pkg::CFG_W-1:0] i_cfg_data
);
    import btb_pkg::*;

    // configuration
    logic [2:0] r_index_bits;
    logic [3:0] r_history_bits;
    logic [4:0] r_tag_bits;
    logic [1:0] r_init;
    logic       r_ghist;
    logic       r_gcnt;
    t_share     r_share;

    t_state r_state, n_state;

    logic                  r_op, r_taken;
    logic [ADDR_W-1:0]     r_pc, r_tgt;

    t_entry                m_entry [ENTRIES];
    t_entry                r_entry_rd;
    logic [ENTRIES-1:0]    r_valid;
    logic [HIST_BITS-1:0]  r_shist;
    logic [1:0]            m_loc [ENTRIES*ROW_LEN];
    logic [1:0]            m_sh [ROW_LEN];
    logic [ROW_LEN-1:0]    r_sh_valid;
    logic [1:0]            r_loc_rd, r_sh_rd;
    logic                  r_sh_ok;
    logic                  r_hit;
    logic [HIST_BITS-1:0]  r_caddr, r_hist;
    logic [HIST_BITS-1:0]  r_walk;
    logic [31:0]           r_branches, r_flushes;

    logic                  r_out_valid, r_out_taken;
    logic [ADDR_W-1:0]     r_out_target;

    // effective configuration
    logic [2:0]            ib;
    logic [3:0]            hb;
    logic [4:0]            tb, tb_max;
    logic [HIST_BITS-1:0]  hmask;

    assign ib     = (r_index_bits > 3'd5) ? 3'd5 : r_index_bits;
    assign hb     = (r_history_bits == 4'd0) ? 4'd1 :
                    (r_history_bits > 4'd8) ? 4'd8 : r_history_bits;
    assign tb_max = 5'(TAG_W) - {2'b00, ib};
    assign tb     = (r_tag_bits > tb_max) ? tb_max : r_tag_bits;
    assign hmask  = HIST_BITS'((9'd1 << hb) - 9'd1);

    function automatic logic [ENTRY_BITS-1:0] idx_of(input logic [ADDR_W-1:0] pc,
                                                     input logic [2:0] b);
        logic [ENTRY_BITS-1:0] m;
        m = ENTRY_BITS'((6'd1 << b) - 6'd1);
        return pc[ENTRY_BITS+1:2] & m;
    endfunction

    logic                  req_fire;
    logic [ENTRY_BITS-1:0] idx;
    logic [TAG_W-1:0]      tag;
    logic [HIST_BITS-1:0]  xv, hist, sel, cs, caddr;
    logic                  hit;

    assign req_fire = i_req.valid && i_req.ready;
    assign idx  = idx_of(r_pc, ib);
    assign tag  = (r_pc[ADDR_W-1:2] >> ib) & ~({TAG_W{1'b1}} << tb);

    always_comb begin
        unique case (r_share)
            SHARE_LOW:  xv = r_pc[HIST_BITS+1:2] & hmask;
            SHARE_HIGH: xv = r_pc[HIST_BITS+15:16] & hmask;
            default:    xv = '0;
        endcase
    end

    assign hist  = r_ghist ? r_shist : r_entry_rd.hist;
    assign hit   = r_valid[idx] && (r_entry_rd.tag == tag);
    assign sel   = (hist ^ xv) & hmask;
    assign cs    = ((r_ghist ? r_shist : '0) ^ xv) & hmask;
    assign caddr = (r_op && !hit) ? cs : sel;

    // execute stage
    logic [1:0]            cval, cnew;
    logic                  exec_fire, flush, pred;
    logic [HIST_BITS-1:0]  hist_sh;
    logic                  walk_done;

    assign cval      = r_gcnt ? (r_sh_ok ? r_sh_rd : r_init) : r_loc_rd;
    assign cnew      = step_counter(cval, r_taken);
    assign exec_fire = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign pred      = !r_op && r_hit && cval[1];
    assign hist_sh   = ((r_hist << 1) | HIST_BITS'(r_taken)) & hmask;
    assign walk_done = (r_walk == hmask);

    always_comb begin
        if (!r_hit) begin
            flush = r_taken;
        end else if (r_taken) begin
            flush = (r_entry_rd.target != r_tgt) || !cval[1];
        end else begin
            flush = cval[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) begin
                n_state = S_READ;
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: if (exec_fire) begin
                n_state = (r_op && !r_hit && !r_gcnt) ? S_WALK : S_IDLE;
            end
            S_WALK: if (walk_done) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    // request capture and reads
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op       <= i_req.op;
            r_pc       <= i_req.pc;
            r_tgt      <= i_req.target;
            r_taken    <= i_req.taken;
            r_entry_rd <= m_entry[idx_of(i_req.pc, ib)];
        end
        if (r_state == S_READ) begin
            r_loc_rd <= m_loc[{idx, caddr}];
            r_sh_rd  <= m_sh[caddr];
            r_sh_ok  <= r_sh_valid[caddr];
            r_hit    <= hit;
            r_caddr  <= caddr;
            r_hist   <= hist;
        end
    end

    // memory writes
    t_entry                entry_wr;
    logic                  loc_we;
    logic [HIST_BITS-1:0]  loc_col;
    logic [1:0]            loc_val;

    always_comb begin
        entry_wr.tag    = r_hit ? r_entry_rd.tag : tag;
        entry_wr.target = r_tgt;
        if (r_ghist) begin
            entry_wr.hist = r_entry_rd.hist;
        end else begin
            entry_wr.hist = r_hit ? hist_sh : HIST_BITS'(r_taken);
        end
        if (r_state == S_WALK) begin
            loc_we  = 1'b1;
            loc_col = r_walk;
            loc_val = (r_walk == r_caddr) ? step_counter(r_init, r_taken) : r_init;
        end else begin
            loc_we  = exec_fire && r_op && r_hit && !r_gcnt;
            loc_col = r_caddr;
            loc_val = cnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire && r_op) begin
            m_entry[idx] <= entry_wr;
        end
        if (exec_fire && r_op && r_gcnt) begin
            m_sh[r_caddr] <= cnew;
        end
        if (loc_we) begin
            m_loc[{idx, loc_col}] <= loc_val;
        end
    end

    // control state, counts and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits   <= '0;
            r_history_bits <= 4'd1;
            r_tag_bits     <= '0;
            r_init         <= 2'd1;
            r_ghist        <= 1'b0;
            r_gcnt         <= 1'b0;
            r_share        <= SHARE_NONE;
            r_valid        <= '0;
            r_sh_valid     <= '0;
            r_shist        <= '0;
            r_branches     <= '0;
            r_flushes      <= '0;
            r_out_valid    <= 1'b0;
            r_walk         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INDEX_BITS:   r_index_bits   <= i_cfg_data[2:0];
                CFG_HISTORY_BITS: r_history_bits <= i_cfg_data[3:0];
                CFG_TAG_BITS:     r_tag_bits     <= i_cfg_data[4:0];
                CFG_INIT_COUNTER: r_init         <= i_cfg_data[1:0];
                CFG_GLOBAL_HIST:  r_ghist        <= i_cfg_data[0];
                CFG_GLOBAL_CNT:   r_gcnt         <= i_cfg_data[0];
                CFG_SHARE_MODE:   r_share        <= t_share'(i_cfg_data[1:0]);
                default: ;
            endcase
            if (i_cfg_idx != CFG_UNUSED) begin
                r_valid    <= '0;
                r_sh_valid <= '0;
                r_shist    <= '0;
                r_branches <= '0;
                r_flushes  <= '0;
            end
        end else begin
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_WALK) begin
                r_walk <= r_walk + HIST_BITS'(1);
            end else begin
                r_walk <= '0;
            end
            if (exec_fire) begin
                if (r_op) begin
                    r_branches   <= r_branches + 32'd1;
                    r_valid[idx] <= 1'b1;
                    if (flush) begin
                        r_flushes <= r_flushes + 32'd1;
                    end
                    if (r_ghist) begin
                        r_shist <= hist_sh;
                    end
                    if (r_gcnt) begin
                        r_sh_valid[r_caddr] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_taken  <= pred;
            r_out_target <= pred ? r_entry_rd.target : r_pc + 32'd4;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.predicted_taken  = r_out_taken;
    assign o_rsp.predicted_target = r_out_target;
    assign o_rsp.branch_count     = r_branches;
    assign o_rsp.flush_count      = r_flushes;

`ifndef SYNTHESIS
    a_walk_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !r_gcnt)
        else $error("row walk with shared counters");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_walk & ~hmask) == '0))
        else $error("row walk beyond history length");
    a_flush_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cfg_we) && $past(i_rst_n) |->
        (r_flushes == $past(r_flushes)) || (r_flushes == $past(r_flushes) + 32'd1))
        else $error("flush count jumped");
    a_flush_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flushes != $past(r_flushes)) && !$past(i_cfg_we) && $past(i_rst_n) |->
        (r_branches == $past(r_branches) + 32'd1))
        else $error("flush counted without an update");
`endif

endmodule
